### sv/ctsc_pkg.sv
// Shared types, constants and helper functions for the C-subset token scanner.
// Used by ctsc_scan_core, ctsc_result_fifo and c_subset_token_scanner_top.
`default_nettype none

package ctsc_pkg;

  // Counter width for the line and offset counters (8..32).
  localparam int COUNTER_BITS  = 24;
  // Identifier bytes kept for keyword matching (6..8).
  localparam int KEYWORD_CHARS = 6;

  localparam int CNT_W   = COUNTER_BITS;
  localparam int KW_W    = KEYWORD_CHARS * 8;
  localparam int FIELD_W = 24;
  localparam int KIND_W  = 5;
  localparam int WIDE_W  = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
  localparam int KW_TBL_W = 64;
  localparam int KW_COUNT = 8;

  // Result queue depth; one item makes at most two results.
  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [KW_W-1:0]    kwin_t;
  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [FIELD_W-1:0] field_t;

  localparam cnt_t CNT_MAX = {CNT_W{1'b1}};
  localparam cnt_t CNT_ONE = CNT_W'(1);
  localparam cnt_t CNT_TWO = CNT_W'(2);

  typedef enum logic [3:0] {
    MODE_IDLE       = 4'd0,
    MODE_IDENT      = 4'd1,
    MODE_NUMBER     = 4'd2,
    MODE_SLASH      = 4'd3,
    MODE_LINE_CMT   = 4'd4,
    MODE_BLOCK_CMT  = 4'd5,
    MODE_BLOCK_STAR = 4'd6,
    MODE_LT         = 4'd7,
    MODE_GT         = 4'd8,
    MODE_EQ         = 4'd9
  } mode_t;

  localparam kind_t KIND_EOF      = 5'd0;
  localparam kind_t KIND_INT      = 5'd1;
  localparam kind_t KIND_LPAREN   = 5'd9;
  localparam kind_t KIND_RPAREN   = 5'd10;
  localparam kind_t KIND_LBRACE   = 5'd11;
  localparam kind_t KIND_RBRACE   = 5'd12;
  localparam kind_t KIND_LBRACKET = 5'd13;
  localparam kind_t KIND_RBRACKET = 5'd14;
  localparam kind_t KIND_SEMI     = 5'd15;
  localparam kind_t KIND_COMMA    = 5'd16;
  localparam kind_t KIND_PLUS     = 5'd17;
  localparam kind_t KIND_MINUS    = 5'd18;
  localparam kind_t KIND_STAR     = 5'd19;
  localparam kind_t KIND_SLASH    = 5'd20;
  localparam kind_t KIND_ASSIGN   = 5'd21;
  localparam kind_t KIND_LT       = 5'd22;
  localparam kind_t KIND_GT       = 5'd23;
  localparam kind_t KIND_LE       = 5'd24;
  localparam kind_t KIND_GE       = 5'd25;
  localparam kind_t KIND_EQ       = 5'd26;
  localparam kind_t KIND_AMP      = 5'd27;
  localparam kind_t KIND_IDENT    = 5'd28;
  localparam kind_t KIND_NUMBER   = 5'd29;
  localparam kind_t KIND_ERROR    = 5'd30;

  // Keywords, right-justified ASCII, in kind order starting at KIND_INT.
  localparam logic [KW_TBL_W-1:0] KW_TABLE [KW_COUNT] = '{
    64'h0000_0000_0069_6e74,  // int
    64'h0000_0000_6368_6172,  // char
    64'h0000_0000_6c6f_6e67,  // long
    64'h0000_7374_7275_6374,  // struct
    64'h0000_7265_7475_726e,  // return
    64'h0000_0000_0000_6966,  // if
    64'h0000_0000_656c_7365,  // else
    64'h0000_0077_6869_6c65   // while
  };

  typedef struct packed {
    kind_t  kind;
    field_t line;
    field_t start;
    field_t len;
    logic   last;
  } tok_t;

  // Result bundle from the scan core for one byte.
  typedef struct packed {
    logic [1:0] n;
    tok_t       r0;
    tok_t       r1;
  } res_bundle_t;

  function automatic cnt_t sat_inc(cnt_t v);
    return (v == CNT_MAX) ? v : cnt_t'(v + CNT_ONE);
  endfunction

  function automatic field_t to_field(cnt_t v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return w[FIELD_W-1:0];
  endfunction

  function automatic tok_t make_tok(kind_t k, cnt_t line, cnt_t start, cnt_t len);
    tok_t t;
    t.kind  = k;
    t.line  = to_field(line);
    t.start = to_field(start);
    t.len   = to_field(len);
    t.last  = 1'b0;
    return t;
  endfunction

  // Kind of a one-byte punctuation token, KIND_EOF when the byte is none.
  function automatic kind_t single_kind(logic [7:0] b);
    kind_t k;
    case (b)
      8'h28:   k = KIND_LPAREN;    // (
      8'h29:   k = KIND_RPAREN;    // )
      8'h7b:   k = KIND_LBRACE;    // {
      8'h7d:   k = KIND_RBRACE;    // }
      8'h5b:   k = KIND_LBRACKET;  // [
      8'h5d:   k = KIND_RBRACKET;  // ]
      8'h3b:   k = KIND_SEMI;      // ;
      8'h2c:   k = KIND_COMMA;     // ,
      8'h2b:   k = KIND_PLUS;      // +
      8'h2d:   k = KIND_MINUS;     // -
      8'h2a:   k = KIND_STAR;      // *
      8'h26:   k = KIND_AMP;       // &
      default: k = KIND_EOF;
    endcase
    return k;
  endfunction

  function automatic kind_t keyword_kind(kwin_t w, logic ovf);
    logic [KW_TBL_W-1:0] wide;
    kind_t k;
    wide = KW_TBL_W'(w);
    k = KIND_IDENT;
    if (!ovf) begin
      for (int i = 0; i < KW_COUNT; i++) begin
        if (wide == KW_TABLE[i]) begin
          k = kind_t'(KIND_INT + kind_t'(i));
        end
      end
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### sv/c_subset_token_scanner_top.sv
// Top level of the C-subset token scanner: input register, scan core, result queue.
// Depends on ctsc_pkg, ctsc_scan_core and ctsc_result_fifo.
//
//   channel | ports                                   | beat
//   --------+-----------------------------------------+------------------------------
//   in      | in_valid/in_ready, in_text_byte,        | one source byte or an
//           | in_end_of_text                          | end-of-text marker
//   out     | out_valid/out_ready, out_token_kind,    | one token; last_of_run flags
//           | out_line_number, out_start_offset,      | the final token of an input
//           | out_token_length, out_last_of_run       | beat
//
// One input beat per cycle sustained while the result queue has room. A beat is
// held in the input register and decoded there, and its tokens (zero, one or two)
// are registered into a four-entry result queue that drives out_*.
// A beat is decoded only while the queue has room for two tokens, so a
// stalled consumer backs up through the queue into in_ready.
// Reset (rst_n low, synchronous) returns the scanner to line 1, offset 0 and
// empties both the input register and the queue.
`default_nettype none

module c_subset_token_scanner_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [4:0]       out_token_kind,
  output logic [23:0]      out_line_number,
  output logic [23:0]      out_start_offset,
  output logic [23:0]      out_token_length,
  output logic             out_last_of_run
);

  // Input register
  logic       in_full_r, in_full_nxt;
  logic [7:0] in_byte_r;
  logic       in_eot_r;
  logic       in_take;

  // Decode handoff
  logic                  step;
  logic                  room;
  ctsc_pkg::res_bundle_t bundle;
  ctsc_pkg::tok_t        head;

  assign step     = in_full_r && room;
  assign in_ready = !in_full_r || step;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    in_full_nxt = in_take || (in_full_r && !step);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_full_r <= 1'b0;
    end else begin
      in_full_r <= in_full_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_text_byte;
      in_eot_r  <= in_end_of_text;
    end
  end

  ctsc_scan_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .text_byte   (in_byte_r),
    .end_of_text (in_eot_r),
    .res         (bundle)
  );

  ctsc_result_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step),
    .bundle     (bundle),
    .room       (room),
    .head_valid (out_valid),
    .head_ready (out_ready),
    .head       (head)
  );

  assign out_token_kind   = head.kind;
  assign out_line_number  = head.line;
  assign out_start_offset = head.start;
  assign out_token_length = head.len;
  assign out_last_of_run  = head.last;

endmodule

`default_nettype wire

### sv/ctsc_scan_core.sv
// Scanner state and the per-byte decode: next state plus up to two tokens.
// Depends on ctsc_pkg.
`default_nettype none

module ctsc_scan_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 step,
  input  wire logic [7:0]           text_byte,
  input  wire logic                 end_of_text,
  output ctsc_pkg::res_bundle_t     res
);

  ctsc_pkg::mode_t mode_r, mode_nxt;
  ctsc_pkg::kwin_t win_r, win_nxt;
  logic            ovf_r, ovf_nxt;
  ctsc_pkg::cnt_t  line_r, line_nxt;
  ctsc_pkg::cnt_t  off_r, off_nxt;
  ctsc_pkg::cnt_t  tstart_r, tstart_nxt;
  ctsc_pkg::cnt_t  tline_r, tline_nxt;
  logic            err_r, err_nxt;

  logic [7:0]      b;
  logic            b_digit, b_alpha, b_space, b_nl;
  ctsc_pkg::kind_t single_k;
  logic            fresh, flush_has, start_has, pair_has;
  ctsc_pkg::tok_t  flush_tok, start_tok, pair_tok, eof_tok;
  ctsc_pkg::kind_t flush_k, pair_k;
  ctsc_pkg::cnt_t  flush_len;
  logic            a_v, c_v;
  ctsc_pkg::tok_t  a_tok, c_tok;

  assign b        = text_byte;
  assign b_digit  = b inside {[8'h30:8'h39]};
  assign b_alpha  = (b inside {[8'h61:8'h7a], [8'h41:8'h5a]}) || (b == 8'h5f);
  assign b_space  = (b == 8'h20) || (b inside {[8'h09:8'h0d]});
  assign b_nl     = (b == 8'h0a);
  assign single_k = ctsc_pkg::single_kind(b);

  // Shared decode
  always_comb begin
    case (mode_r)
      ctsc_pkg::MODE_LINE_CMT,
      ctsc_pkg::MODE_BLOCK_CMT,
      ctsc_pkg::MODE_BLOCK_STAR: fresh = 1'b0;
      ctsc_pkg::MODE_SLASH:      fresh = (b != 8'h2f) && (b != 8'h2a);
      ctsc_pkg::MODE_LT,
      ctsc_pkg::MODE_GT,
      ctsc_pkg::MODE_EQ:         fresh = (b != 8'h3d);
      ctsc_pkg::MODE_IDENT:      fresh = !(b_alpha || b_digit);
      ctsc_pkg::MODE_NUMBER:     fresh = !b_digit;
      default:                   fresh = 1'b1;
    endcase
  end

  always_comb begin
    flush_has = 1'b1;
    flush_len = ctsc_pkg::CNT_ONE;
    case (mode_r)
      ctsc_pkg::MODE_IDENT: begin
        flush_k   = ctsc_pkg::keyword_kind(win_r, ovf_r);
        flush_len = ctsc_pkg::cnt_t'(off_r - tstart_r);
      end
      ctsc_pkg::MODE_NUMBER: begin
        flush_k   = ctsc_pkg::KIND_NUMBER;
        flush_len = ctsc_pkg::cnt_t'(off_r - tstart_r);
      end
      ctsc_pkg::MODE_SLASH: flush_k = ctsc_pkg::KIND_SLASH;
      ctsc_pkg::MODE_LT:    flush_k = ctsc_pkg::KIND_LT;
      ctsc_pkg::MODE_GT:    flush_k = ctsc_pkg::KIND_GT;
      ctsc_pkg::MODE_EQ:    flush_k = ctsc_pkg::KIND_ASSIGN;
      default: begin
        flush_k   = ctsc_pkg::KIND_EOF;
        flush_has = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (mode_r)
      ctsc_pkg::MODE_LT: pair_k = ctsc_pkg::KIND_LE;
      ctsc_pkg::MODE_GT: pair_k = ctsc_pkg::KIND_GE;
      default:           pair_k = ctsc_pkg::KIND_EQ;
    endcase
  end

  assign pair_has = ((mode_r == ctsc_pkg::MODE_LT) || (mode_r == ctsc_pkg::MODE_GT) ||
                     (mode_r == ctsc_pkg::MODE_EQ)) && (b == 8'h3d);
  // Bytes that open no pending token and are not whitespace give a token now
  assign start_has = !b_space && !b_digit && !b_alpha && (b != 8'h2f) &&
                     (b != 8'h3c) && (b != 8'h3e) && (b != 8'h3d);

  assign flush_tok = ctsc_pkg::make_tok(flush_k, tline_r, tstart_r, flush_len);
  assign pair_tok  = ctsc_pkg::make_tok(pair_k, tline_r, tstart_r, ctsc_pkg::CNT_TWO);
  assign start_tok = ctsc_pkg::make_tok(
                       (single_k != ctsc_pkg::KIND_EOF) ? single_k : ctsc_pkg::KIND_ERROR,
                       line_r, off_r, ctsc_pkg::CNT_ONE);
  assign eof_tok   = ctsc_pkg::make_tok(ctsc_pkg::KIND_EOF, line_r, off_r, '0);

  // Next state
  always_comb begin
    mode_nxt   = mode_r;
    win_nxt    = win_r;
    ovf_nxt    = ovf_r;
    line_nxt   = line_r;
    off_nxt    = off_r;
    tstart_nxt = tstart_r;
    tline_nxt  = tline_r;
    err_nxt    = err_r;
    if (end_of_text) begin
      mode_nxt   = ctsc_pkg::MODE_IDLE;
      win_nxt    = '0;
      ovf_nxt    = 1'b0;
      line_nxt   = ctsc_pkg::CNT_ONE;
      off_nxt    = '0;
      tstart_nxt = '0;
      tline_nxt  = ctsc_pkg::CNT_ONE;
      err_nxt    = 1'b0;
    end else if (!err_r) begin
      case (mode_r)
        ctsc_pkg::MODE_LINE_CMT: begin
          if (b_nl) begin
            line_nxt = ctsc_pkg::sat_inc(line_r);
            mode_nxt = ctsc_pkg::MODE_IDLE;
          end
        end
        ctsc_pkg::MODE_BLOCK_CMT,
        ctsc_pkg::MODE_BLOCK_STAR: begin
          if ((mode_r == ctsc_pkg::MODE_BLOCK_STAR) && (b == 8'h2f)) begin
            mode_nxt = ctsc_pkg::MODE_IDLE;
          end else begin
            if (b_nl) begin
              line_nxt = ctsc_pkg::sat_inc(line_r);
            end
            mode_nxt = (b == 8'h2a) ? ctsc_pkg::MODE_BLOCK_STAR : ctsc_pkg::MODE_BLOCK_CMT;
          end
        end
        ctsc_pkg::MODE_SLASH: begin
          if (b == 8'h2f) begin
            mode_nxt = ctsc_pkg::MODE_LINE_CMT;
          end else if (b == 8'h2a) begin
            mode_nxt = ctsc_pkg::MODE_BLOCK_CMT;
          end
        end
        ctsc_pkg::MODE_LT,
        ctsc_pkg::MODE_GT,
        ctsc_pkg::MODE_EQ: begin
          if (b == 8'h3d) begin
            mode_nxt = ctsc_pkg::MODE_IDLE;
          end
        end
        ctsc_pkg::MODE_IDENT: begin
          if (b_alpha || b_digit) begin
            if (win_r[ctsc_pkg::KW_W-1 -: 8] != 8'h00) begin
              ovf_nxt = 1'b1;
            end
            win_nxt = {win_r[ctsc_pkg::KW_W-9:0], b};
          end
        end
        default: begin
        end
      endcase
      if (fresh) begin
        mode_nxt = ctsc_pkg::MODE_IDLE;
        if (b_space) begin
          if (b_nl) begin
            line_nxt = ctsc_pkg::sat_inc(line_r);
          end
        end else if (!start_has) begin
          tstart_nxt = off_r;
          tline_nxt  = line_r;
          if (b == 8'h2f) begin
            mode_nxt = ctsc_pkg::MODE_SLASH;
          end else if (b == 8'h3c) begin
            mode_nxt = ctsc_pkg::MODE_LT;
          end else if (b == 8'h3e) begin
            mode_nxt = ctsc_pkg::MODE_GT;
          end else if (b == 8'h3d) begin
            mode_nxt = ctsc_pkg::MODE_EQ;
          end else if (b_digit) begin
            mode_nxt = ctsc_pkg::MODE_NUMBER;
          end else begin
            mode_nxt = ctsc_pkg::MODE_IDENT;
            win_nxt  = ctsc_pkg::KW_W'(b);
            ovf_nxt  = 1'b0;
          end
        end else if (single_k == ctsc_pkg::KIND_EOF) begin
          err_nxt = 1'b1;
        end
      end
      off_nxt = ctsc_pkg::sat_inc(off_r);
    end
  end

  // Results: first and second candidate, then packed to the front
  always_comb begin
    a_v   = 1'b0;
    c_v   = 1'b0;
    a_tok = flush_tok;
    c_tok = start_tok;
    if (end_of_text) begin
      a_v   = !err_r && flush_has;
      c_v   = 1'b1;
      c_tok = eof_tok;
    end else if (!err_r) begin
      if (pair_has) begin
        a_v   = 1'b1;
        a_tok = pair_tok;
      end else if (fresh) begin
        a_v = flush_has;
        c_v = start_has;
      end
    end
    res.r1 = c_tok;
    if (a_v) begin
      res.r0      = a_tok;
      res.n       = c_v ? 2'd2 : 2'd1;
      res.r0.last = !c_v;
      res.r1.last = 1'b1;
    end else begin
      res.r0      = c_tok;
      res.n       = c_v ? 2'd1 : 2'd0;
      res.r0.last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= ctsc_pkg::MODE_IDLE;
      win_r    <= '0;
      ovf_r    <= 1'b0;
      line_r   <= ctsc_pkg::CNT_ONE;
      off_r    <= '0;
      tstart_r <= '0;
      tline_r  <= ctsc_pkg::CNT_ONE;
      err_r    <= 1'b0;
    end else if (step) begin
      mode_r   <= mode_nxt;
      win_r    <= win_nxt;
      ovf_r    <= ovf_nxt;
      line_r   <= line_nxt;
      off_r    <= off_nxt;
      tstart_r <= tstart_nxt;
      tline_r  <= tline_nxt;
      err_r    <= err_nxt;
    end
  end

  // End of text always closes with an EOF token
  a_eot_eof: assert property (@(posedge clk) disable iff (!rst_n)
    (step && end_of_text) |->
      ((res.n == 2'd1) && (res.r0.kind == ctsc_pkg::KIND_EOF)) ||
      ((res.n == 2'd2) && (res.r1.kind == ctsc_pkg::KIND_EOF)))
    else $error("end of text without trailing EOF token");

  // Sticky error swallows input
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (step && err_r && !end_of_text) |-> (res.n == 2'd0))
    else $error("token produced after error");

  // A consumed byte moves the offset off zero
  a_off_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !err_r && !end_of_text) |=> (off_r != '0))
    else $error("byte offset did not advance");

endmodule

`default_nettype wire

### sv/ctsc_result_fifo.sv
// Small result queue: takes up to two tokens a cycle, hands out one a cycle while head_ready is high.
// Depends on ctsc_pkg.
`default_nettype none

module ctsc_result_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire ctsc_pkg::res_bundle_t bundle,
  output logic                       room,
  output logic                       head_valid,
  input  wire logic                  head_ready,
  output ctsc_pkg::tok_t             head
);

  ctsc_pkg::tok_t mem [ctsc_pkg::RES_DEPTH];
  logic [ctsc_pkg::RES_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [ctsc_pkg::RES_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [ctsc_pkg::RES_CNT_W-1:0] count_r, count_nxt;
  logic [ctsc_pkg::RES_CNT_W-1:0] push_n;
  logic                           pop;

  assign head_valid = (count_r != '0);
  assign head       = mem[rd_ptr_r];
  assign pop        = head_valid && head_ready;
  // Room for a worst-case pair after this cycle's pop
  assign room = ctsc_pkg::RES_CNT_W'(count_r - ctsc_pkg::RES_CNT_W'(pop)) <=
                ctsc_pkg::RES_CNT_W'(ctsc_pkg::RES_DEPTH - 2);
  assign push_n = push ? ctsc_pkg::RES_CNT_W'(bundle.n) : '0;

  always_comb begin
    wr_ptr_nxt = ctsc_pkg::RES_PTR_W'(wr_ptr_r + push_n);
    rd_ptr_nxt = ctsc_pkg::RES_PTR_W'(rd_ptr_r + ctsc_pkg::RES_PTR_W'(pop));
    count_nxt  = ctsc_pkg::RES_CNT_W'(count_r + push_n - ctsc_pkg::RES_CNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (push && (bundle.n != 2'd0)) begin
      mem[wr_ptr_r] <= bundle.r0;
    end
    if (push && (bundle.n == 2'd2)) begin
      mem[ctsc_pkg::RES_PTR_W'(wr_ptr_r + 1'b1)] <= bundle.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ctsc_pkg::RES_CNT_W'(ctsc_pkg::RES_DEPTH))
    else $error("result queue overflow");

endmodule

`default_nettype wire

### tb/tb.sv
// Testbench for c_subset_token_scanner_top: streams source-text beats, predicts tokens in
// a behavioral scanner model and checks every output token field by field.
// Depends on ctsc_pkg (kinds, scan modes, token struct) and the scanner RTL.
module tb;

  localparam int ITEM_TARGET   = 950;   // input beats before the random part stops
  localparam int HOLD_CYCLES   = 400;   // long consumer hold-off
  localparam int QUIET_LIMIT   = 3000;  // cycles with no handshake before giving up
  localparam int DRAIN_SETTLE  = 16;    // extra cycles once all tokens have arrived

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_text_byte;
  logic        in_end_of_text;
  logic        out_valid;
  logic        out_ready;
  logic [4:0]  out_token_kind;
  logic [23:0] out_line_number;
  logic [23:0] out_start_offset;
  logic [23:0] out_token_length;
  logic        out_last_of_run;

  c_subset_token_scanner_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_text_byte     (in_text_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_token_kind   (out_token_kind),
    .out_line_number  (out_line_number),
    .out_start_offset (out_start_offset),
    .out_token_length (out_token_length),
    .out_last_of_run  (out_last_of_run)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Test control
  int beats_sent;
  int mismatch_count;
  int tokens_checked;
  int quiet_cycles;
  bit calm;       // no random idling on either side while set
  bit hold_req;   // ask the consumer for one long hold-off

  string kw_names[8]  = '{"int", "char", "long", "struct", "return", "if", "else", "while"};
  string pair_ops[3]  = '{"<=", ">=", "=="};
  string punct_chars  = "(){}[];,+-*&";
  string lone_ops     = "<>=/";

  // ---------------------------------------------------------------------------
  // Scanner prediction
  // ---------------------------------------------------------------------------
  ctsc_pkg::mode_t scan_state;
  ctsc_pkg::kwin_t id_window;   // last identifier bytes, right-justified
  logic            id_long;     // identifier outgrew the window
  ctsc_pkg::cnt_t  cur_line;
  ctsc_pkg::cnt_t  cur_off;
  ctsc_pkg::cnt_t  tok_off;
  ctsc_pkg::cnt_t  tok_line;
  logic            in_error;

  ctsc_pkg::tok_t beat_tokens[$];       // tokens produced by the beat being predicted
  ctsc_pkg::tok_t expected_tokens[$];   // tokens still owed by the block

  function automatic ctsc_pkg::cnt_t bump_count(ctsc_pkg::cnt_t v);
    return (v == '1) ? v : ctsc_pkg::cnt_t'(v + 1'b1);
  endfunction

  function automatic bit is_blank(logic [7:0] b);
    return b == 8'h20 || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function automatic bit is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic bit is_word_start(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
  endfunction

  function automatic ctsc_pkg::kind_t punct_kind(logic [7:0] b);
    case (b)
      "(":     return ctsc_pkg::KIND_LPAREN;
      ")":     return ctsc_pkg::KIND_RPAREN;
      "{":     return ctsc_pkg::KIND_LBRACE;
      "}":     return ctsc_pkg::KIND_RBRACE;
      "[":     return ctsc_pkg::KIND_LBRACKET;
      "]":     return ctsc_pkg::KIND_RBRACKET;
      ";":     return ctsc_pkg::KIND_SEMI;
      ",":     return ctsc_pkg::KIND_COMMA;
      "+":     return ctsc_pkg::KIND_PLUS;
      "-":     return ctsc_pkg::KIND_MINUS;
      "*":     return ctsc_pkg::KIND_STAR;
      "&":     return ctsc_pkg::KIND_AMP;
      default: return ctsc_pkg::KIND_EOF;
    endcase
  endfunction

  function automatic ctsc_pkg::kwin_t keyword_bits(string s);
    ctsc_pkg::kwin_t w;
    w = '0;
    for (int i = 0; i < s.len(); i++) w = {w[ctsc_pkg::KW_W-9:0], s[i]};
    return w;
  endfunction

  function automatic ctsc_pkg::kind_t ident_kind();
    ctsc_pkg::kind_t k;
    k = ctsc_pkg::KIND_IDENT;
    if (!id_long) begin
      for (int i = 0; i < 8; i++) begin
        if (keyword_bits(kw_names[i]) == id_window)
          k = ctsc_pkg::kind_t'(ctsc_pkg::KIND_INT + i);
      end
    end
    return k;
  endfunction

  task automatic clear_scanner();
    scan_state = ctsc_pkg::MODE_IDLE;
    id_window  = '0;
    id_long    = 1'b0;
    cur_line   = ctsc_pkg::cnt_t'(1);
    cur_off    = '0;
    tok_off    = '0;
    tok_line   = ctsc_pkg::cnt_t'(1);
    in_error   = 1'b0;
  endtask

  task automatic emit_token(ctsc_pkg::kind_t k, ctsc_pkg::cnt_t line, ctsc_pkg::cnt_t start,
                            ctsc_pkg::cnt_t len);
    ctsc_pkg::tok_t t;
    t.kind  = k;
    t.line  = line;
    t.start = start;
    t.len   = len;
    t.last  = 1'b0;
    beat_tokens.push_back(t);
  endtask

  task automatic flush_open_token();
    case (scan_state)
      ctsc_pkg::MODE_IDENT:
        emit_token(ident_kind(), tok_line, tok_off, ctsc_pkg::cnt_t'(cur_off - tok_off));
      ctsc_pkg::MODE_NUMBER:
        emit_token(ctsc_pkg::KIND_NUMBER, tok_line, tok_off,
                   ctsc_pkg::cnt_t'(cur_off - tok_off));
      ctsc_pkg::MODE_SLASH:
        emit_token(ctsc_pkg::KIND_SLASH, tok_line, tok_off, ctsc_pkg::cnt_t'(1));
      ctsc_pkg::MODE_LT:
        emit_token(ctsc_pkg::KIND_LT, tok_line, tok_off, ctsc_pkg::cnt_t'(1));
      ctsc_pkg::MODE_GT:
        emit_token(ctsc_pkg::KIND_GT, tok_line, tok_off, ctsc_pkg::cnt_t'(1));
      ctsc_pkg::MODE_EQ:
        emit_token(ctsc_pkg::KIND_ASSIGN, tok_line, tok_off, ctsc_pkg::cnt_t'(1));
      default: ;
    endcase
    scan_state = ctsc_pkg::MODE_IDLE;
  endtask

  task automatic open_token(ctsc_pkg::mode_t m);
    scan_state = m;
    tok_off    = cur_off;
    tok_line   = cur_line;
  endtask

  // Byte seen with no token open
  task automatic start_token(logic [7:0] b);
    ctsc_pkg::kind_t k;
    k = punct_kind(b);
    if (is_blank(b)) begin
      if (b == 8'h0a) cur_line = bump_count(cur_line);
    end else if (b == "/") begin
      open_token(ctsc_pkg::MODE_SLASH);
    end else if (b == "<") begin
      open_token(ctsc_pkg::MODE_LT);
    end else if (b == ">") begin
      open_token(ctsc_pkg::MODE_GT);
    end else if (b == "=") begin
      open_token(ctsc_pkg::MODE_EQ);
    end else if (is_digit(b)) begin
      open_token(ctsc_pkg::MODE_NUMBER);
    end else if (is_word_start(b)) begin
      open_token(ctsc_pkg::MODE_IDENT);
      id_window = ctsc_pkg::kwin_t'(b);
      id_long   = 1'b0;
    end else if (k != ctsc_pkg::KIND_EOF) begin
      emit_token(k, cur_line, cur_off, ctsc_pkg::cnt_t'(1));
    end else begin
      // stray byte: error token, then everything is dropped until end of text
      emit_token(ctsc_pkg::KIND_ERROR, cur_line, cur_off, ctsc_pkg::cnt_t'(1));
      in_error   = 1'b1;
      scan_state = ctsc_pkg::MODE_IDLE;
    end
  endtask

  task automatic predict_beat(logic [7:0] b, logic eot);
    logic            restart;
    ctsc_pkg::kind_t pair_kind;
    ctsc_pkg::tok_t  t;
    beat_tokens.delete();
    restart = 1'b0;
    if (eot) begin
      if (!in_error) flush_open_token();
      emit_token(ctsc_pkg::KIND_EOF, cur_line, cur_off, '0);
      clear_scanner();
    end else if (!in_error) begin
      case (scan_state)
        ctsc_pkg::MODE_LINE_CMT: begin
          if (b == 8'h0a) begin
            cur_line   = bump_count(cur_line);
            scan_state = ctsc_pkg::MODE_IDLE;
          end
        end
        ctsc_pkg::MODE_BLOCK_CMT, ctsc_pkg::MODE_BLOCK_STAR: begin
          if (scan_state == ctsc_pkg::MODE_BLOCK_STAR && b == "/") begin
            scan_state = ctsc_pkg::MODE_IDLE;
          end else begin
            if (b == 8'h0a) cur_line = bump_count(cur_line);
            scan_state = (b == "*") ? ctsc_pkg::MODE_BLOCK_STAR : ctsc_pkg::MODE_BLOCK_CMT;
          end
        end
        ctsc_pkg::MODE_SLASH: begin
          if (b == "/") scan_state = ctsc_pkg::MODE_LINE_CMT;
          else if (b == "*") scan_state = ctsc_pkg::MODE_BLOCK_CMT;
          else restart = 1'b1;
        end
        ctsc_pkg::MODE_LT, ctsc_pkg::MODE_GT, ctsc_pkg::MODE_EQ: begin
          if (b == "=") begin
            pair_kind = (scan_state == ctsc_pkg::MODE_LT) ? ctsc_pkg::KIND_LE :
                        (scan_state == ctsc_pkg::MODE_GT) ? ctsc_pkg::KIND_GE :
                                                            ctsc_pkg::KIND_EQ;
            emit_token(pair_kind, tok_line, tok_off, ctsc_pkg::cnt_t'(2));
            scan_state = ctsc_pkg::MODE_IDLE;
          end else begin
            restart = 1'b1;
          end
        end
        ctsc_pkg::MODE_IDENT: begin
          if (is_word_start(b) || is_digit(b)) begin
            if (id_window[ctsc_pkg::KW_W-1 -: 8] != 8'h00) id_long = 1'b1;
            id_window = {id_window[ctsc_pkg::KW_W-9:0], b};
          end else begin
            restart = 1'b1;
          end
        end
        ctsc_pkg::MODE_NUMBER: begin
          if (!is_digit(b)) restart = 1'b1;
        end
        default: begin
          scan_state = ctsc_pkg::MODE_IDLE;
          restart    = 1'b1;
        end
      endcase
      if (restart) begin
        flush_open_token();
        start_token(b);
      end
      cur_off = bump_count(cur_off);
    end
    foreach (beat_tokens[i]) begin
      t = beat_tokens[i];
      t.last = (i == beat_tokens.size() - 1);
      expected_tokens.push_back(t);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("mismatch at token %0d: %s got %0d want %0d", tokens_checked, what, got, want);
  endtask

  always @(posedge clk) begin : check_tokens
    ctsc_pkg::tok_t got;
    ctsc_pkg::tok_t want;
    if (rst_n && out_valid && out_ready) begin
      got.kind  = out_token_kind;
      got.line  = out_line_number;
      got.start = out_start_offset;
      got.len   = out_token_length;
      got.last  = out_last_of_run;
      if (expected_tokens.size() == 0) begin
        report_mismatch("unexpected token, kind", got.kind, -1);
      end else begin
        want = expected_tokens.pop_front();
        if (got.kind != want.kind)   report_mismatch("kind", got.kind, want.kind);
        if (got.line != want.line)   report_mismatch("line", got.line, want.line);
        if (got.start != want.start) report_mismatch("offset", got.start, want.start);
        if (got.len != want.len)     report_mismatch("length", got.len, want.len);
        if (got.last != want.last)   report_mismatch("last_of_run", got.last, want.last);
      end
      tokens_checked++;
    end
  end

  // Give up if neither channel moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Consumer: random ready, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready <= calm || ($urandom_range(99) >= 20);
    end
  end

  // ---------------------------------------------------------------------------
  // Producer
  // ---------------------------------------------------------------------------
  // Entered and left at a falling edge; valid stays up between back-to-back beats.
  task automatic send_beat(logic [7:0] b, logic eot);
    while (!calm && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    predict_beat(b, eot);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_end();
    send_beat(8'($urandom_range(255)), 1'b1);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // Stop offering and wait for every owed token, then let the pipe settle
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk);
    repeat (DRAIN_SETTLE) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Random source text
  // ---------------------------------------------------------------------------
  logic [7:0] src_text[$];

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) src_text.push_back(s[i]);
  endtask

  function automatic logic [7:0] rand_word_char(bit allow_digit);
    int r;
    r = $urandom_range(allow_digit ? 62 : 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r == 52) return "_";
    return 8'("0" + r - 53);
  endfunction

  // Plain names, keywords with a prefix or suffix (window overflow for the longest keywords), keyword prefixes
  task automatic add_identifier();
    string kw;
    int    n;
    kw = kw_names[$urandom_range(7)];
    case ($urandom_range(3))
      0: begin
        n = $urandom_range(1, 9);
        src_text.push_back(rand_word_char(0));
        repeat (n - 1) src_text.push_back(rand_word_char(1));
      end
      1: begin
        add_text(kw);
        src_text.push_back(rand_word_char(1));
      end
      2: begin
        src_text.push_back(rand_word_char(0));
        add_text(kw);
      end
      default: add_text(kw.substr(0, kw.len() - 2));
    endcase
  endtask

  task automatic add_token();
    int         pick;
    logic [7:0] c;
    logic [7:0] prev;
    pick = $urandom_range(99);
    if (pick < 14) begin
      add_text(kw_names[$urandom_range(7)]);
    end else if (pick < 28) begin
      add_identifier();
    end else if (pick < 38) begin
      repeat ($urandom_range(1, 6)) src_text.push_back(8'("0" + $urandom_range(9)));
    end else if (pick < 52) begin
      src_text.push_back(punct_chars[$urandom_range(11)]);
    end else if (pick < 60) begin
      add_text(pair_ops[$urandom_range(2)]);
    end else if (pick < 68) begin
      src_text.push_back(lone_ops[$urandom_range(3)]);
    end else if (pick < 78) begin
      repeat ($urandom_range(1, 3))
        src_text.push_back($urandom_range(1) ? 8'h20 : 8'($urandom_range(9, 13)));
    end else if (pick < 84) begin
      add_text("//");
      repeat ($urandom_range(0, 8)) src_text.push_back(8'($urandom_range(32, 126)));
      src_text.push_back(8'h0a);
    end else if (pick < 91) begin
      // block comment with stars, newlines and slashes, never closed early
      add_text("/*");
      prev = "*";
      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(4))
          0:       c = "*";
          1:       c = 8'h0a;
          2:       c = "/";
          3:       c = 8'h20;
          default: c = "q";
        endcase
        if (c == "/" && prev == "*") c = "q";
        src_text.push_back(c);
        prev = c;
      end
      if ($urandom_range(1)) add_text("*/");
      else add_text("**/");
    end else if (pick < 98) begin
      src_text.push_back(8'h0a);
    end else begin
      src_text.push_back(8'($urandom_range(255)));
    end
  endtask

  // One program: mostly well-formed token runs, sometimes noise or an open comment
  task automatic gen_program();
    int shape;
    src_text.delete();
    shape = $urandom_range(9);
    if (shape == 0) begin
      repeat ($urandom_range(3, 12)) src_text.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(3, 18)) begin
        add_token();
        if ($urandom_range(1)) src_text.push_back(8'h20);
      end
      if (shape == 1) add_text("/* open");
    end
  endtask

  task automatic send_program();
    foreach (src_text[i]) send_beat(src_text[i], 1'b0);
    send_end();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Every punctuation kind, the paired operators and their lone forms
  task automatic test_punctuation_and_operators();
    send_text("(){}[];,+-*&<=>===< > =/x");
    send_end();
  endtask

  // Line and block comments, line counting, a keyword and an underscore name
  task automatic test_comments_and_lines();
    send_text("//c\n/*\n**/9_a\tint");
    send_beat(8'h0b, 1'b0);
    send_end();
  endtask

  // Stray bytes: NUL mid-identifier and a high byte; the rest is ignored till end of text
  task automatic test_error_sticky();
    send_text("a");
    send_beat(8'h00, 1'b0);
    send_text("b\n");
    send_beat(8'hff, 1'b0);
    send_end();
    send_beat(8'h80, 1'b0);
    send_end();
  endtask

  // Pending tokens flushed by end of text; open comments dropped
  task automatic test_end_of_text_flush();
    send_end();
    send_text("astruct");
    send_end();
    send_text("<");
    send_end();
    send_text("/*x");
    send_end();
    send_text("//");
    send_end();
  endtask

  // Consumer stalls long enough for the block to fill and back up the input
  task automatic test_backpressure();
    calm     = 1'b1;
    hold_req = 1'b1;
    repeat (3) begin
      gen_program();
      send_program();
    end
    calm = 1'b0;
  endtask

  // Producer pauses until every owed token has come out, then resumes
  task automatic test_drain_pause();
    repeat (2) begin
      gen_program();
      send_program();
      wait_for_drain();
    end
  endtask

  task automatic test_random_programs();
    int calm_until;
    calm_until = beats_sent + 200;
    calm = 1'b1;
    while (beats_sent < calm_until) begin
      gen_program();
      send_program();
    end
    calm = 1'b0;
    while (beats_sent < ITEM_TARGET) begin
      gen_program();
      send_program();
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_text_byte   = 8'h00;
    in_end_of_text = 1'b0;
    calm           = 1'b0;
    hold_req       = 1'b0;
    beats_sent     = 0;
    mismatch_count = 0;
    tokens_checked = 0;
    quiet_cycles   = 0;
    clear_scanner();
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_punctuation_and_operators();
    test_comments_and_lines();
    test_error_sticky();
    test_end_of_text_flush();
    test_backpressure();
    test_drain_pause();
    test_random_programs();

    wait_for_drain();
    if (mismatch_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

### sim.f
sv/ctsc_pkg.sv
sv/ctsc_scan_core.sv
sv/ctsc_result_fifo.sv
sv/c_subset_token_scanner_top.sv
tb/tb.sv
